FILE: rtl/core/stlr_pkg.sv
// shared types and constants of the scrollback text line ring
package stlr_pkg;

	// store geometry
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 32;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	// register widths
	localparam int COLS_W   = COL_W + 1;
	localparam int ROWS_W   = ROW_W + 1;
	localparam int SCROLL_W = ROW_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// remainder unit widths: sum of three row values, divisor up to MAX_ROWS
	localparam int MOD_W = ROW_W + 2;
	localparam int DIV_W = ROWS_W;
	localparam int CNT_W = $clog2(MOD_W + 1);

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 3'd3;

	// character codes
	localparam logic [7:0] CHAR_TERM    = 8'd0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       char_code;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} item_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic [ROW_W-1:0] write_row;
		logic [COL_W-1:0] write_col;
		logic [ROW_W-1:0] window_first_row;
		logic             dropped;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [ROW_W-1:0] rem;
	} mod_rsp_t;

endpackage

FILE: rtl/core/stlr_ram.sv
// generic single-port ram with registered read
module stlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/core/stlr_mod.sv
// bit-serial remainder unit for row arithmetic modulo the rows in use
module stlr_mod import stlr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] sh_q;
	logic [DIV_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [MOD_W-1:0] trial;
	logic [MOD_W-1:0] step_rem;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q[MOD_W-2:0], sh_q[MOD_W-1]};
		step_rem = (trial >= MOD_W'(div_q)) ? trial - MOD_W'(div_q) : trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			if (req.dividend < MOD_W'(req.divisor)) begin
				cnt_q  <= '0;
				done_q <= 1'b1;
			end else begin
				cnt_q  <= CNT_W'(MOD_W);
				done_q <= 1'b0;
			end
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			if (req.dividend < MOD_W'(req.divisor)) begin
				rem_q <= req.dividend;
			end else begin
				rem_q <= '0;
				sh_q  <= req.dividend;
			end
		end else if (cnt_q != '0) begin
			rem_q <= step_rem;
			sh_q  <= {sh_q[MOD_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[ROW_W-1:0];

endmodule

FILE: rtl/core/scrollback_text_line_ring.sv
// Scrollback text line ring: a 32 x 64 byte line store in one single-port RAM with
// write, clear, read and no-op actions, one result per item. After reset and after every
// clear action the store is swept to zero, one byte a cycle, during which no item is
// taken (a clear's result follows its sweep). A plain character is stored and then
// reported; a line advance adds a row remainder from the bit-serial remainder unit,
// and a window move a second remainder. A read takes one remainder plus a RAM read.
// Configuration is always ready and must change only while the block is idle.
module scrollback_text_line_ring import stlr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_WRAP    = 4'd2;
	localparam logic [3:0] S_STORE   = 4'd3;
	localparam logic [3:0] S_ADV     = 4'd4;
	localparam logic [3:0] S_ADV_ROW = 4'd5;
	localparam logic [3:0] S_ADV_WIN = 4'd6;
	localparam logic [3:0] S_RD_MOD  = 4'd7;
	localparam logic [3:0] S_RD_WAIT = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]          state_q;
	logic [COLS_W-1:0]   cols_in_use_q;
	logic [ROWS_W-1:0]   rows_in_use_q;
	logic                wrap_enable_q;
	logic [SCROLL_W-1:0] scroll_offset_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    win_start_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                report_q;
	logic                ret_store_q;
	logic [7:0]          ch_q;
	logic [COL_W-1:0]    rcol_q;
	logic [7:0]          rdata_q;
	logic                drop_q;
	logic                out_valid_q;
	result_t             out_q;

	logic [COLS_W-1:0]   eff_cols;
	logic [DIV_W-1:0]    eff_rows;
	logic                accept;
	logic                full;
	logic                slot_free;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [7:0]          ram_wdata;
	logic [7:0]          ram_rdata;
	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;
	logic [COL_W-1:0]    last_col;

	// clamped geometry
	always_comb begin
		if (cols_in_use_q < COLS_W'(2)) begin
			eff_cols = COLS_W'(2);
		end else if (cols_in_use_q > COLS_W'(MAX_COLS)) begin
			eff_cols = COLS_W'(MAX_COLS);
		end else begin
			eff_cols = cols_in_use_q;
		end
		if (rows_in_use_q == '0) begin
			eff_rows = DIV_W'(1);
		end else if (rows_in_use_q > ROWS_W'(MAX_ROWS)) begin
			eff_rows = DIV_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_in_use_q;
		end
	end

	assign last_col   = COL_W'(eff_cols - 1'b1);
	assign full       = ({1'b0, cur_col_q} + COLS_W'(1)) >= eff_cols;
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign slot_free  = !out_valid_q || !result_stall;
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use_q   <= COLS_W'(MAX_COLS);
			rows_in_use_q   <= ROWS_W'(MAX_ROWS);
			wrap_enable_q   <= 1'b1;
			scroll_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COLS:   cols_in_use_q   <= cfg_data[COLS_W-1:0];
				CFG_ROWS:   rows_in_use_q   <= cfg_data[ROWS_W-1:0];
				CFG_WRAP:   wrap_enable_q   <= cfg_data[0];
				CFG_SCROLL: scroll_offset_q <= cfg_data[SCROLL_W-1:0];
				default: ;
			endcase
		end
	end

	// ram port and remainder requests per state
	always_comb begin
		ram_we           = 1'b0;
		ram_addr         = {cur_row_q, cur_col_q};
		ram_wdata        = CHAR_TERM;
		mod_req.start    = 1'b0;
		mod_req.dividend = {2'b00, cur_row_q} + MOD_W'(1);
		mod_req.divisor  = eff_rows;
		case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_cnt_q;
			end
			S_IDLE: begin
				if (accept && item.action == ACT_READ) begin
					mod_req.start    = 1'b1;
					mod_req.dividend = MOD_W'(win_start_q) + MOD_W'(scroll_offset_q)
						+ MOD_W'(item.read_row);
				end
			end
			S_WRAP: begin
				ram_we   = 1'b1;
				ram_addr = {cur_row_q, last_col};
			end
			S_STORE: begin
				ram_we    = 1'b1;
				ram_wdata = (ch_q == CHAR_NEWLINE) ? CHAR_TERM : ch_q;
			end
			S_ADV: begin
				mod_req.start = 1'b1;
			end
			S_ADV_ROW: begin
				if (mod_rsp.done && mod_rsp.rem == win_start_q) begin
					mod_req.start    = 1'b1;
					mod_req.dividend = MOD_W'(win_start_q) + MOD_W'(1);
				end
			end
			S_RD_MOD: begin
				ram_addr = {mod_rsp.rem, rcol_q};
			end
			default: ;
		endcase
	end

	// sequencer and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			report_q    <= 1'b0;
			ret_store_q <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			win_start_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= report_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (item.action)
							ACT_WRITE: begin
								if (full && wrap_enable_q) begin
									state_q <= S_WRAP;
								end else if (full) begin
									ret_store_q <= 1'b0;
									state_q <= (item.char_code == CHAR_NEWLINE) ? S_ADV : S_DONE;
								end else begin
									state_q <= S_STORE;
								end
							end
							ACT_CLEAR: begin
								cur_row_q   <= '0;
								cur_col_q   <= '0;
								win_start_q <= '0;
								clr_cnt_q   <= '0;
								report_q    <= 1'b1;
								state_q     <= S_CLEAR;
							end
							ACT_READ: state_q <= S_RD_MOD;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_WRAP: begin
					ret_store_q <= 1'b1;
					state_q     <= S_ADV;
				end
				S_STORE: begin
					if (ch_q == CHAR_NEWLINE) begin
						ret_store_q <= 1'b0;
						state_q     <= S_ADV;
					end else begin
						if (ch_q != CHAR_TERM) begin
							cur_col_q <= cur_col_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_ADV: begin
					cur_col_q <= '0;
					state_q   <= S_ADV_ROW;
				end
				S_ADV_ROW: begin
					if (mod_rsp.done) begin
						cur_row_q <= mod_rsp.rem;
						if (mod_rsp.rem == win_start_q) begin
							state_q <= S_ADV_WIN;
						end else begin
							state_q <= ret_store_q ? S_STORE : S_DONE;
						end
					end
				end
				S_ADV_WIN: begin
					if (mod_rsp.done) begin
						win_start_q <= mod_rsp.rem;
						state_q     <= ret_store_q ? S_STORE : S_DONE;
					end
				end
				S_RD_MOD: begin
					if (mod_rsp.done) begin
						state_q <= ({1'b0, rcol_q} < eff_cols) ? S_RD_WAIT : S_DONE;
					end
				end
				S_RD_WAIT: state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						report_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and per-item result data
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= item.char_code;
			rcol_q  <= item.read_col;
			rdata_q <= '0;
			drop_q  <= (item.action == ACT_WRITE) && full && !wrap_enable_q;
		end else if (state_q == S_RD_WAIT) begin
			rdata_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			out_q.read_data        <= report_q ? 8'd0 : rdata_q;
			out_q.write_row        <= cur_row_q;
			out_q.write_col        <= cur_col_q;
			out_q.window_first_row <= win_start_q;
			out_q.dropped          <= report_q ? 1'b0 : drop_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	stlr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	stlr_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mod_req),
		.rsp   (mod_rsp)
	);

	// a remainder always lands inside the rows in use
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> (DIV_W'(mod_rsp.rem) < eff_rows))
		else $error("row remainder out of range");

	// an accepted clear starts the sweep
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.action == ACT_CLEAR) |=> (state_q == S_CLEAR && clr_cnt_q == '0))
		else $error("clear did not start the sweep");

	// a dropped character only happens with wrapping off
	a_drop_nowrap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.dropped) |-> !wrap_enable_q)
		else $error("drop reported with wrapping on");

endmodule
